[rtl/core/i2c_master_register_access_assert.svh]
// Assertion macros shared by the I2C register access master.
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define IMRA_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define IMRA_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/imra_pkg.sv]
// Package with the types, codes and sizes of the I2C register access master.
`timescale 1ns / 1ps

package imra_pkg;

   // Field widths and burst length limit.
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 9;
   localparam int STATUS_W    = 3;
   localparam int MAX_READ    = 256;
   localparam logic [LEN_W-1:0] MAX_READ_LEN = LEN_W'(MAX_READ);

   // Request queue between the front and the back; the depth is a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Register port.
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int IDLE_TO_W   = 16;
   localparam int ACK_TO_W    = 8;
   localparam logic [IDLE_TO_W-1:0] IDLE_TIMEOUT_RESET = 16'd1000;
   localparam logic [ACK_TO_W-1:0]  ACK_TIMEOUT_RESET  = 8'd250;

   typedef enum logic [0:0] {
      REG_IDLE_TIMEOUT = 1'b0,
      REG_ACK_TIMEOUT  = 1'b1
   } reg_index_type;

   // Request kinds and operations.
   localparam logic       KIND_CMD      = 1'b1;
   localparam logic [1:0] OP_BYTE_WRITE = 2'd0;
   localparam logic [1:0] OP_BYTE_READ  = 2'd1;

   // Direction bit of the device address byte.
   localparam logic [BYTE_W-1:0] DIR_WRITE_MASK = 8'hFE;
   localparam logic [BYTE_W-1:0] DIR_READ_BIT   = 8'h01;

   // Completion status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BUS_BUSY    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_ADDR_NACK   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_REG_NACK    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_DATA_NACK   = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_RADDR_NACK  = 3'd5;

   // Classified request as it sits in the queue.
   typedef struct packed {
      logic              is_cmd;
      logic              op_write;
      logic [BYTE_W-1:0] dev_addr;
      logic [BYTE_W-1:0] reg_addr;
      logic [BYTE_W-1:0] write_data;
      logic [LEN_W-1:0]  bytes_init;
      logic              sda_sample;
   } req_item_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   // Timeout settings from the register port.
   typedef struct packed {
      logic [IDLE_TO_W-1:0] idle_timeout;
      logic [ACK_TO_W-1:0]  ack_timeout;
   } cfg_type;

   // One result.
   typedef struct packed {
      logic                scl_level;
      logic                sda_release;
      logic [BYTE_W-1:0]   read_byte;
      logic                read_valid;
      logic                last_byte;
      logic                done_res;
      logic [STATUS_W-1:0] status;
      logic                busy_res;
   } rsp_item_type;

endpackage

[rtl/core/imra_front.sv]
// Front end: takes requests, classifies them and pushes them into the queue.
`timescale 1ns / 1ps

module imra_front
   import imra_pkg::*;
(
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic [1:0]           req_op,
   input  logic [BYTE_W-1:0]    req_dev_addr,
   input  logic [BYTE_W-1:0]    req_reg_addr,
   input  logic [BYTE_W-1:0]    req_write_data,
   input  logic [LEN_W-1:0]     req_read_len,
   input  logic                 req_sda_sample,
   input  queue_status_type     q_stat,
   output logic                 push,
   output req_item_type         push_item
);

   logic [LEN_W-1:0] len_clamped;

   // The request waits while the queue has no room.
   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   // A zero length reads one byte; lengths above the limit are cut to it.
   always_comb begin
      if (req_read_len == '0) begin
         len_clamped = LEN_W'(1);
      end else if (req_read_len > MAX_READ_LEN) begin
         len_clamped = MAX_READ_LEN;
      end else begin
         len_clamped = req_read_len;
      end
   end

   // Byte count for the read phase: none for a write, one for a byte read, the clamped length otherwise.
   always_comb begin
      push_item.is_cmd     = (req_kind == KIND_CMD);
      push_item.op_write   = (req_op == OP_BYTE_WRITE);
      push_item.dev_addr   = req_dev_addr;
      push_item.reg_addr   = req_reg_addr;
      push_item.write_data = req_write_data;
      push_item.sda_sample = req_sda_sample;
      if (req_op == OP_BYTE_WRITE) begin
         push_item.bytes_init = '0;
      end else if (req_op == OP_BYTE_READ) begin
         push_item.bytes_init = LEN_W'(1);
      end else begin
         push_item.bytes_init = len_clamped;
      end
   end

endmodule

[rtl/core/imra_queue.sv]
// Short request queue that decouples the front end from the bus sequencer.
`timescale 1ns / 1ps

module imra_queue
   import imra_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  req_item_type     push_item,
   input  logic             pop,
   output req_item_type     head_item,
   output queue_status_type q_stat
);

   req_item_type           entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   do_push;
   logic                   do_pop;

   assign q_stat.valid = (count_ff != '0);
   assign q_stat.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && q_stat.valid;
   assign head_item    = entries_ff[rd_ptr_ff];

   // Occupancy after this cycle's push and pop.
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   // Pointers wrap on their own since the depth is a power of two.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
      end
   end

   // Entry storage holds payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/core/imra_back.sv]
// Back end: the bus phase sequencer and the registered result stage.
`timescale 1ns / 1ps

module imra_back
   import imra_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  queue_status_type q_stat,
   input  req_item_type     head_item,
   output logic             pop,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output rsp_item_type     rsp_item
);

   // Half-bit bus phases.
   typedef enum logic [16:0] {
      PH_IDLE    = 17'h00001,
      PH_IDLECHK = 17'h00002,
      PH_START_W = 17'h00004,
      PH_TX_LO   = 17'h00008,
      PH_TX_HI   = 17'h00010,
      PH_ACK_LO  = 17'h00020,
      PH_ACK_HI  = 17'h00040,
      PH_RS_LO   = 17'h00080,
      PH_RS_HI   = 17'h00100,
      PH_START_R = 17'h00200,
      PH_RD_LO   = 17'h00400,
      PH_RD_HI   = 17'h00800,
      PH_MA_LO   = 17'h01000,
      PH_MA_HI   = 17'h02000,
      PH_SP_LO   = 17'h04000,
      PH_SP_HI   = 17'h08000,
      PH_SP_END  = 17'h10000
   } phase_type;

   // Which byte the transmit phases are sending.
   typedef enum logic [1:0] {
      GRP_AW = 2'd0,
      GRP_RG = 2'd1,
      GRP_WD = 2'd2,
      GRP_AR = 2'd3
   } grp_type;

   phase_type           phase_ff, phase_in;
   grp_type             grp_ff, grp_in;
   logic [3:0]          bit_count_ff, bit_count_in;
   logic [BYTE_W-1:0]   shift_ff, shift_in;
   logic [LEN_W-1:0]    bytes_left_ff, bytes_left_in;
   logic [IDLE_TO_W-1:0] wait_ff, wait_in;
   logic [STATUS_W-1:0] stop_code_ff, stop_code_in;
   logic                op_write_ff, op_write_in;
   logic [BYTE_W-1:0]   dev_ff, dev_in;
   logic [BYTE_W-1:0]   reg_ff, reg_in;
   logic [BYTE_W-1:0]   wd_ff, wd_in;
   logic                rsp_valid_ff;
   rsp_item_type        rsp_ff, rsp_in;
   logic [3:0]          bit_inc;
   logic [IDLE_TO_W:0]  wait_inc;
   logic [BYTE_W-1:0]   shift_rx;
   logic                nack;

   // Status reported when the slave leaves a byte unacknowledged.
   function automatic logic [STATUS_W-1:0] nack_status(input grp_type grp);
      logic [STATUS_W-1:0] code;
      case (grp)
         GRP_AW:  code = STATUS_ADDR_NACK;
         GRP_RG:  code = STATUS_REG_NACK;
         GRP_WD:  code = STATUS_DATA_NACK;
         default: code = STATUS_RADDR_NACK;
      endcase
      return code;
   endfunction

   // A new step is taken whenever a request waits and the result slot is free.
   assign pop       = q_stat.valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   assign bit_inc  = bit_count_ff + 4'd1;
   assign wait_inc = {1'b0, wait_ff} + (IDLE_TO_W + 1)'(1);
   assign shift_rx = {shift_ff[BYTE_W-2:0], head_item.sda_sample};
   assign nack     = (bytes_left_ff <= LEN_W'(1));

   // Line levels of the current phase.
   always_comb begin
      case (phase_ff)
         PH_TX_LO: begin
            rsp_in.scl_level   = 1'b0;
            rsp_in.sda_release = shift_ff[BYTE_W-1];
         end
         PH_TX_HI: begin
            rsp_in.scl_level   = 1'b1;
            rsp_in.sda_release = shift_ff[BYTE_W-1];
         end
         PH_ACK_LO, PH_RS_LO, PH_RD_LO: begin
            rsp_in.scl_level   = 1'b0;
            rsp_in.sda_release = 1'b1;
         end
         PH_START_W, PH_START_R, PH_SP_HI: begin
            rsp_in.scl_level   = 1'b1;
            rsp_in.sda_release = 1'b0;
         end
         PH_MA_LO: begin
            rsp_in.scl_level   = 1'b0;
            rsp_in.sda_release = nack;
         end
         PH_MA_HI: begin
            rsp_in.scl_level   = 1'b1;
            rsp_in.sda_release = nack;
         end
         PH_SP_LO: begin
            rsp_in.scl_level   = 1'b0;
            rsp_in.sda_release = 1'b0;
         end
         default: begin
            rsp_in.scl_level   = 1'b1;
            rsp_in.sda_release = 1'b1;
         end
      endcase
   end

   // Sequencer step for one request.
   always_comb begin
      phase_in          = phase_ff;
      grp_in            = grp_ff;
      bit_count_in      = bit_count_ff;
      shift_in          = shift_ff;
      bytes_left_in     = bytes_left_ff;
      wait_in           = wait_ff;
      stop_code_in      = stop_code_ff;
      op_write_in       = op_write_ff;
      dev_in            = dev_ff;
      reg_in            = reg_ff;
      wd_in             = wd_ff;
      rsp_in.read_byte  = '0;
      rsp_in.read_valid = 1'b0;
      rsp_in.last_byte  = 1'b0;
      rsp_in.done_res   = 1'b0;
      rsp_in.status     = STATUS_OK;

      if (head_item.is_cmd) begin
         // A command starts a transaction only from idle; otherwise it is dropped.
         if (phase_ff == PH_IDLE) begin
            op_write_in   = head_item.op_write;
            dev_in        = head_item.dev_addr;
            reg_in        = head_item.reg_addr;
            wd_in         = head_item.write_data;
            bytes_left_in = head_item.bytes_init;
            wait_in       = '0;
            bit_count_in  = '0;
            shift_in      = '0;
            phase_in      = PH_IDLECHK;
         end
      end else begin
         case (phase_ff)
            PH_IDLECHK: begin
               if (head_item.sda_sample) begin
                  wait_in  = '0;
                  phase_in = PH_START_W;
               end else begin
                  wait_in = wait_inc[IDLE_TO_W-1:0];
                  if (wait_inc > {1'b0, cfg.idle_timeout}) begin
                     wait_in         = '0;
                     rsp_in.done_res = 1'b1;
                     rsp_in.status   = STATUS_BUS_BUSY;
                     phase_in        = PH_IDLE;
                  end
               end
            end
            PH_START_W: begin
               shift_in     = dev_ff & DIR_WRITE_MASK;
               bit_count_in = '0;
               grp_in       = GRP_AW;
               phase_in     = PH_TX_LO;
            end
            PH_TX_LO: begin
               phase_in = PH_TX_HI;
            end
            PH_TX_HI: begin
               shift_in     = {shift_ff[BYTE_W-2:0], 1'b0};
               bit_count_in = bit_inc;
               phase_in     = bit_inc[3] ? PH_ACK_LO : PH_TX_LO;
            end
            PH_ACK_LO: begin
               wait_in  = '0;
               phase_in = PH_ACK_HI;
            end
            PH_ACK_HI: begin
               if (!head_item.sda_sample) begin
                  // Acknowledged: move on to the next part of the transaction.
                  case (grp_ff)
                     GRP_AW: begin
                        shift_in     = reg_ff;
                        bit_count_in = '0;
                        grp_in       = GRP_RG;
                        phase_in     = PH_TX_LO;
                     end
                     GRP_RG: begin
                        if (op_write_ff) begin
                           shift_in     = wd_ff;
                           bit_count_in = '0;
                           grp_in       = GRP_WD;
                           phase_in     = PH_TX_LO;
                        end else begin
                           phase_in = PH_RS_LO;
                        end
                     end
                     GRP_WD: begin
                        stop_code_in = STATUS_OK;
                        phase_in     = PH_SP_LO;
                     end
                     default: begin
                        shift_in     = '0;
                        bit_count_in = '0;
                        phase_in     = PH_RD_LO;
                     end
                  endcase
               end else begin
                  wait_in = wait_inc[IDLE_TO_W-1:0];
                  if (wait_inc > (IDLE_TO_W + 1)'(cfg.ack_timeout)) begin
                     stop_code_in = nack_status(grp_ff);
                     phase_in     = PH_SP_LO;
                  end
               end
            end
            PH_RS_LO: begin
               phase_in = PH_RS_HI;
            end
            PH_RS_HI: begin
               phase_in = PH_START_R;
            end
            PH_START_R: begin
               shift_in     = dev_ff | DIR_READ_BIT;
               bit_count_in = '0;
               grp_in       = GRP_AR;
               phase_in     = PH_TX_LO;
            end
            PH_RD_LO: begin
               phase_in = PH_RD_HI;
            end
            PH_RD_HI: begin
               shift_in     = shift_rx;
               bit_count_in = bit_inc;
               if (bit_inc[3]) begin
                  rsp_in.read_byte  = shift_rx;
                  rsp_in.read_valid = 1'b1;
                  rsp_in.last_byte  = nack;
                  phase_in          = PH_MA_LO;
               end else begin
                  phase_in = PH_RD_LO;
               end
            end
            PH_MA_LO: begin
               phase_in = PH_MA_HI;
            end
            PH_MA_HI: begin
               if (nack) begin
                  bytes_left_in = '0;
                  stop_code_in  = STATUS_OK;
                  phase_in      = PH_SP_LO;
               end else begin
                  bytes_left_in = bytes_left_ff - LEN_W'(1);
                  shift_in      = '0;
                  bit_count_in  = '0;
                  phase_in      = PH_RD_LO;
               end
            end
            PH_SP_LO: begin
               phase_in = PH_SP_HI;
            end
            PH_SP_HI: begin
               phase_in = PH_SP_END;
            end
            PH_SP_END: begin
               rsp_in.done_res = 1'b1;
               rsp_in.status   = stop_code_ff;
               bit_count_in    = '0;
               phase_in        = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end

      rsp_in.busy_res = (phase_in != PH_IDLE);
   end

   // Sequencer state advances only on a step.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         grp_ff        <= GRP_AW;
         bit_count_ff  <= '0;
         shift_ff      <= '0;
         bytes_left_ff <= '0;
         wait_ff       <= '0;
         stop_code_ff  <= STATUS_OK;
      end else if (pop) begin
         phase_ff      <= phase_in;
         grp_ff        <= grp_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         bytes_left_ff <= bytes_left_in;
         wait_ff       <= wait_in;
         stop_code_ff  <= stop_code_in;
      end
   end

   // Latched transaction fields are loaded by a command before any use.
   always_ff @(posedge clock) begin
      if (pop) begin
         op_write_ff <= op_write_in;
         dev_ff      <= dev_in;
         reg_ff      <= reg_in;
         wd_ff       <= wd_in;
      end
   end

   // Result register: filled on a step, emptied when the consumer takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[rtl/core/i2c_master_register_access.sv]
// Top level of the I2C register access master with its register port.
//
//   Channel   Direction   Handshake                         Carries
//   req_      in          req_valid / req_stall             command or bus tick
//   rsp_      out         rsp_valid / rsp_stall             line levels, read byte, done
//   csr_      in/out      csr_psel / csr_penable / pready   idle and ACK timeouts
//
// One request is taken per clock while req_stall is low; each gives one result, which passes through
// the queue and the result register. The phase sequencer takes one step per request it pops.
// Reset is synchronous: the queue empties and the sequencer returns to idle.
// A stalled result holds; two requests queue behind it before req_stall rises.
`timescale 1ns / 1ps

module i2c_master_register_access
   import imra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [1:0]            req_op,
   input  logic [BYTE_W-1:0]     req_dev_addr,
   input  logic [BYTE_W-1:0]     req_reg_addr,
   input  logic [BYTE_W-1:0]     req_write_data,
   input  logic [LEN_W-1:0]      req_read_len,
   input  logic                  req_sda_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_scl_level,
   output logic                  rsp_sda_release,
   output logic [BYTE_W-1:0]     rsp_read_byte,
   output logic                  rsp_read_valid,
   output logic                  rsp_last_byte,
   output logic                  rsp_done_res,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_busy_res,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   `include "i2c_master_register_access_assert.svh"

   logic [IDLE_TO_W-1:0] idle_timeout_ff;
   logic [ACK_TO_W-1:0]  ack_timeout_ff;
   reg_index_type        csr_index;
   logic                 csr_write;
   cfg_type              cfg;
   queue_status_type     q_stat;
   req_item_type         push_item;
   req_item_type         head_item;
   rsp_item_type         rsp_item;
   logic                 push;
   logic                 pop;

   // Register port: registers sit at byte addresses 0 and 4.
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_timeout_ff <= IDLE_TIMEOUT_RESET;
         ack_timeout_ff  <= ACK_TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_IDLE_TIMEOUT: idle_timeout_ff <= csr_pwdata[IDLE_TO_W-1:0];
            REG_ACK_TIMEOUT:  ack_timeout_ff  <= csr_pwdata[ACK_TO_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_IDLE_TIMEOUT: csr_prdata = CSR_DATA_W'(idle_timeout_ff);
         REG_ACK_TIMEOUT:  csr_prdata = CSR_DATA_W'(ack_timeout_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.idle_timeout = idle_timeout_ff;
   assign cfg.ack_timeout  = ack_timeout_ff;

   // Front end, queue and sequencer.
   imra_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_op         (req_op),
      .req_dev_addr   (req_dev_addr),
      .req_reg_addr   (req_reg_addr),
      .req_write_data (req_write_data),
      .req_read_len   (req_read_len),
      .req_sda_sample (req_sda_sample),
      .q_stat         (q_stat),
      .push           (push),
      .push_item      (push_item)
   );

   imra_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_stat    (q_stat)
   );

   imra_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_stat    (q_stat),
      .head_item (head_item),
      .pop       (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // Result fields.
   assign rsp_scl_level   = rsp_item.scl_level;
   assign rsp_sda_release = rsp_item.sda_release;
   assign rsp_read_byte   = rsp_item.read_byte;
   assign rsp_read_valid  = rsp_item.read_valid;
   assign rsp_last_byte   = rsp_item.last_byte;
   assign rsp_done_res    = rsp_item.done_res;
   assign rsp_status      = rsp_item.status;
   assign rsp_busy_res    = rsp_item.busy_res;

   // A finished transaction always leaves the block idle.
   `IMRA_ASSERT_IMPLY(a_done_leaves_idle, rsp_valid && rsp_done_res, !rsp_busy_res, "done while still busy")
   // Received bytes only appear in the middle of a transaction.
   `IMRA_ASSERT_IMPLY(a_read_while_busy, rsp_valid && rsp_read_valid, rsp_busy_res && !rsp_done_res, "read byte outside a transaction")
   // A queued request moves into a free result slot at the next edge.
   `IMRA_ASSERT_NEXT(a_queue_drains, q_stat.valid && !rsp_valid, rsp_valid, "queued request not moved to the result slot")

endmodule

[test/tb_i2c_master_register_access.sv]
// Self-checking testbench for the I2C register access master.
`timescale 1ns / 1ps

module tb_i2c_master_register_access;
   import imra_pkg::*;

   // Request kinds and operations that the package leaves unnamed.
   localparam logic       KIND_TICK     = 1'b0;
   localparam logic [1:0] OP_BURST_READ = 2'd2;
   localparam logic [1:0] OP_RESERVED   = 2'd3;

   // Sequencer phases; a byte group spans four phases (bit low, bit high, ACK low, ACK high).
   localparam logic [4:0] PH_IDLE       = 5'd0;
   localparam logic [4:0] PH_IDLE_CHECK = 5'd1;
   localparam logic [4:0] PH_START_W    = 5'd2;
   localparam logic [4:0] GRP_ADDR_W    = 5'd3;
   localparam logic [4:0] GRP_REG       = 5'd7;
   localparam logic [4:0] GRP_DATA      = 5'd11;
   localparam logic [4:0] PH_RS_LO      = 5'd15;
   localparam logic [4:0] PH_RS_HI      = 5'd16;
   localparam logic [4:0] PH_START_R    = 5'd17;
   localparam logic [4:0] GRP_ADDR_R    = 5'd18;
   localparam logic [4:0] PH_RD_LO      = 5'd22;
   localparam logic [4:0] PH_RD_HI      = 5'd23;
   localparam logic [4:0] PH_MACK_LO    = 5'd24;
   localparam logic [4:0] PH_MACK_HI    = 5'd25;
   localparam logic [4:0] PH_STOP_LO    = 5'd26;
   localparam logic [4:0] PH_STOP_HI    = 5'd27;
   localparam logic [4:0] PH_STOP_END   = 5'd28;
   localparam logic [4:0] NO_GROUP      = 5'd0;

   // Timeout settings and line activity of the random phases.
   localparam int IDLE_SETTINGS [4] = '{65535, 1, 30, 12};
   localparam int ACK_SETTINGS  [4] = '{255, 1, 0, 20};
   localparam int SEND_IDLE_PCT [4] = '{0, 82, 0, 17};
   localparam int STALL_PCT     [4] = '{0, 0, 82, 17};
   localparam int PHASE_REQUESTS    = 450;

   typedef struct packed {
      logic              kind;
      logic [1:0]        op;
      logic [BYTE_W-1:0] dev_addr;
      logic [BYTE_W-1:0] reg_addr;
      logic [BYTE_W-1:0] write_data;
      logic [LEN_W-1:0]  read_len;
      logic              sda_sample;
   } bus_req_t;

   typedef struct {
      bus_req_t     req;
      bit           typed;
      rsp_item_type want;
   } stim_row_t;

   // Results that can be read straight off the behavior.
   localparam rsp_item_type RSP_IDLE =
      '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b0};
   localparam rsp_item_type RSP_CHECKING =
      '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, STATUS_OK, 1'b1};
   localparam rsp_item_type RSP_BUS_BUSY =
      '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, STATUS_BUS_BUSY, 1'b0};
   localparam rsp_item_type RSP_ADDR_NACK =
      '{1'b1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, STATUS_ADDR_NACK, 1'b0};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_kind = 1'b0;
   logic [1:0]            req_op = 2'd0;
   logic [BYTE_W-1:0]     req_dev_addr = '0;
   logic [BYTE_W-1:0]     req_reg_addr = '0;
   logic [BYTE_W-1:0]     req_write_data = '0;
   logic [LEN_W-1:0]      req_read_len = '0;
   logic                  req_sda_sample = 1'b1;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_scl_level;
   logic                  rsp_sda_release;
   logic [BYTE_W-1:0]     rsp_read_byte;
   logic                  rsp_read_valid;
   logic                  rsp_last_byte;
   logic                  rsp_done_res;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_busy_res;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predicted sequencer state and timeout settings.
   logic [4:0]        seq_phase = PH_IDLE;
   logic [3:0]        bit_cnt = '0;
   logic [BYTE_W-1:0] shift_byte = '0;
   int                bytes_left = 0;
   int                wait_cnt = 0;
   logic [1:0]        lat_op = '0;
   logic [BYTE_W-1:0] lat_dev = '0;
   logic [BYTE_W-1:0] lat_reg = '0;
   logic [BYTE_W-1:0] lat_wd = '0;
   int                idle_limit = 1000;
   int                ack_limit = 250;

   // Slave behavior chosen for the transaction in flight.
   bit                plan_bus_stuck = 1'b0;
   logic [4:0]        plan_nack_group = NO_GROUP;

   rsp_item_type      expected_rsp_q [$];
   stim_row_t         stim_rows [$];
   int                mismatch_count = 0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;

   i2c_master_register_access dut (.*);

   always #4 clock = ~clock;

   // The receiver stalls at random.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // First phase of the byte group that holds phase p, or none.
   function automatic logic [4:0] byte_group(input logic [4:0] p);
      if (p >= GRP_ADDR_W && p < PH_RS_LO)
         return GRP_ADDR_W + ((p - GRP_ADDR_W) / 4) * 4;
      if (p >= GRP_ADDR_R && p < PH_RD_LO)
         return GRP_ADDR_R;
      return NO_GROUP;
   endfunction

   // SCL and SDA levels driven during the current phase.
   function automatic void line_levels(output logic scl, output logic sda);
      logic [4:0] g;
      logic [4:0] off;
      logic       nack_bit;
      g = byte_group(seq_phase);
      nack_bit = (bytes_left <= 1);
      scl = 1'b1;
      sda = 1'b1;
      if (g != NO_GROUP) begin
         off = seq_phase - g;
         scl = off[0];
         sda = (off < 2) ? shift_byte[7] : 1'b1;
      end else begin
         case (seq_phase)
            PH_START_W, PH_START_R: begin
               sda = 1'b0;
            end
            PH_RS_LO, PH_RD_LO: begin
               scl = 1'b0;
            end
            PH_MACK_LO: begin
               scl = 1'b0;
               sda = nack_bit;
            end
            PH_MACK_HI: begin
               sda = nack_bit;
            end
            PH_STOP_LO: begin
               scl = 1'b0;
               sda = 1'b0;
            end
            PH_STOP_HI: begin
               sda = 1'b0;
            end
            default: begin
            end
         endcase
      end
   endfunction

   function automatic void load_byte(input logic [BYTE_W-1:0] value, input logic [4:0] next);
      shift_byte = value;
      bit_cnt = '0;
      seq_phase = next;
   endfunction

   // During the stop phases the bit counter keeps the status to report.
   function automatic void start_stop(input logic [STATUS_W-1:0] code);
      bit_cnt = {1'b0, code};
      seq_phase = PH_STOP_LO;
   endfunction

   // Advances the predicted master by one request and returns its result.
   function automatic rsp_item_type predict_bus_step(input bus_req_t r);
      rsp_item_type o;
      logic [4:0]   g;
      logic [4:0]   off;
      int           len;
      o = '0;
      if (r.kind == KIND_CMD) begin
         // A command is only taken while idle; it never advances the bus.
         if (seq_phase == PH_IDLE) begin
            len = r.read_len;
            if (len == 0) len = 1;
            if (len > MAX_READ) len = MAX_READ;
            lat_op = r.op;
            lat_dev = r.dev_addr;
            lat_reg = r.reg_addr;
            lat_wd = r.write_data;
            bytes_left = (r.op == OP_BYTE_WRITE) ? 0 : (r.op == OP_BYTE_READ) ? 1 : len;
            wait_cnt = 0;
            bit_cnt = '0;
            shift_byte = '0;
            seq_phase = PH_IDLE_CHECK;
         end
         line_levels(o.scl_level, o.sda_release);
      end else begin
         g = byte_group(seq_phase);
         line_levels(o.scl_level, o.sda_release);
         if (g != NO_GROUP) begin
            // Byte sent by the master, then the slave's ACK.
            off = seq_phase - g;
            if (off == 0) begin
               seq_phase = g + 1;
            end else if (off == 1) begin
               shift_byte = shift_byte << 1;
               bit_cnt++;
               seq_phase = (bit_cnt >= 8) ? g + 2 : g;
            end else if (off == 2) begin
               wait_cnt = 0;
               seq_phase = g + 3;
            end else if (!r.sda_sample) begin
               if (g == GRP_ADDR_W) begin
                  load_byte(lat_reg, GRP_REG);
               end else if (g == GRP_REG) begin
                  if (lat_op == OP_BYTE_WRITE) load_byte(lat_wd, GRP_DATA);
                  else seq_phase = PH_RS_LO;
               end else if (g == GRP_DATA) begin
                  start_stop(STATUS_OK);
               end else begin
                  load_byte(8'h00, PH_RD_LO);
               end
            end else begin
               wait_cnt++;
               if (wait_cnt > ack_limit) begin
                  if (g == GRP_ADDR_W) start_stop(STATUS_ADDR_NACK);
                  else if (g == GRP_REG) start_stop(STATUS_REG_NACK);
                  else if (g == GRP_DATA) start_stop(STATUS_DATA_NACK);
                  else start_stop(STATUS_RADDR_NACK);
               end
            end
         end else begin
            case (seq_phase)
               PH_IDLE_CHECK: begin
                  if (r.sda_sample) begin
                     wait_cnt = 0;
                     seq_phase = PH_START_W;
                  end else begin
                     wait_cnt++;
                     if (wait_cnt > idle_limit) begin
                        wait_cnt = 0;
                        o.done_res = 1'b1;
                        o.status = STATUS_BUS_BUSY;
                        seq_phase = PH_IDLE;
                     end
                  end
               end
               PH_START_W: load_byte(lat_dev & DIR_WRITE_MASK, GRP_ADDR_W);
               PH_RS_LO:   seq_phase = PH_RS_HI;
               PH_RS_HI:   seq_phase = PH_START_R;
               PH_START_R: load_byte(lat_dev | DIR_READ_BIT, GRP_ADDR_R);
               PH_RD_LO:   seq_phase = PH_RD_HI;
               PH_RD_HI: begin
                  shift_byte = {shift_byte[6:0], r.sda_sample};
                  bit_cnt++;
                  if (bit_cnt >= 8) begin
                     o.read_byte = shift_byte;
                     o.read_valid = 1'b1;
                     o.last_byte = (bytes_left <= 1);
                     seq_phase = PH_MACK_LO;
                  end else begin
                     seq_phase = PH_RD_LO;
                  end
               end
               PH_MACK_LO: seq_phase = PH_MACK_HI;
               PH_MACK_HI: begin
                  if (bytes_left <= 1) begin
                     bytes_left = 0;
                     start_stop(STATUS_OK);
                  end else begin
                     bytes_left--;
                     load_byte(8'h00, PH_RD_LO);
                  end
               end
               PH_STOP_LO: seq_phase = PH_STOP_HI;
               PH_STOP_HI: seq_phase = PH_STOP_END;
               PH_STOP_END: begin
                  o.done_res = 1'b1;
                  o.status = bit_cnt[2:0];
                  bit_cnt = '0;
                  seq_phase = PH_IDLE;
               end
               default: seq_phase = PH_IDLE;
            endcase
         end
      end
      o.busy_res = (seq_phase != PH_IDLE);
      return o;
   endfunction

   // Picks the next request from the predicted state, acting as a plausible slave.
   function automatic bus_req_t next_bus_request();
      bus_req_t   r;
      logic [4:0] g;
      int         pick;
      r.kind = KIND_TICK;
      r.op = 2'($urandom_range(3));
      r.dev_addr = 8'($urandom_range(255));
      r.reg_addr = 8'($urandom_range(255));
      r.write_data = 8'($urandom_range(255));
      r.read_len = 9'($urandom_range(511));
      r.sda_sample = 1'($urandom_range(1));
      g = byte_group(seq_phase);
      if (seq_phase == PH_IDLE) begin
         // Mostly a new transaction, now and then a tick on the quiet bus.
         if ($urandom_range(9) != 0) begin
            r.kind = KIND_CMD;
            pick = $urandom_range(9);
            r.op = (pick < 3) ? OP_BYTE_WRITE : (pick < 6) ? OP_BYTE_READ :
                   (pick < 9) ? OP_BURST_READ : OP_RESERVED;
            pick = $urandom_range(99);
            if (pick >= 3)
               r.read_len = (pick < 30) ? 9'($urandom_range(15)) : 9'($urandom_range(4, 1));
            plan_bus_stuck = (idle_limit <= 40) && ($urandom_range(7) == 0);
            plan_nack_group = NO_GROUP;
            if (ack_limit <= 40 && $urandom_range(3) == 0) begin
               case ($urandom_range(3))
                  0: plan_nack_group = GRP_ADDR_W;
                  1: plan_nack_group = GRP_REG;
                  2: plan_nack_group = GRP_DATA;
                  default: plan_nack_group = GRP_ADDR_R;
               endcase
            end
         end
      end else if ($urandom_range(29) == 0) begin
         // A command while busy must be ignored.
         r.kind = KIND_CMD;
      end else if (seq_phase == PH_IDLE_CHECK) begin
         r.sda_sample = !plan_bus_stuck && !(wait_cnt < idle_limit && $urandom_range(3) == 0);
      end else if (g != NO_GROUP && seq_phase - g == 3) begin
         r.sda_sample = (g == plan_nack_group) ||
                        (wait_cnt < ack_limit && $urandom_range(3) == 0);
      end
      return r;
   endfunction

   function automatic bus_req_t make_req(input logic kind, input logic [1:0] op,
                                         input logic [7:0] dev, input logic [7:0] ra,
                                         input logic [7:0] wd, input logic [8:0] len,
                                         input logic sda);
      bus_req_t r;
      r = '{kind, op, dev, ra, wd, len, sda};
      return r;
   endfunction

   function automatic void add_row(input bus_req_t r, input bit typed, input rsp_item_type want);
      stim_row_t row;
      row.req = r;
      row.typed = typed;
      row.want = want;
      stim_rows.push_back(row);
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compares every accepted result with the oldest expectation.
   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: result with no request outstanding", $time);
            mismatch_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("scl_level", want.scl_level, rsp_scl_level);
            check_field("sda_release", want.sda_release, rsp_sda_release);
            check_field("read_byte", want.read_byte, rsp_read_byte);
            check_field("read_valid", want.read_valid, rsp_read_valid);
            check_field("last_byte", want.last_byte, rsp_last_byte);
            check_field("done_res", want.done_res, rsp_done_res);
            check_field("status", want.status, rsp_status);
            check_field("busy_res", want.busy_res, rsp_busy_res);
         end
      end
   end

   // Writes one timeout register through a setup and an access cycle.
   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_IDLE_TIMEOUT) idle_limit = value[IDLE_TO_W-1:0];
      else ack_limit = value[ACK_TO_W-1:0];
   endtask

   task automatic wait_for_results();
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   // Sends requests from the row list or from the generator, predicting each accepted one.
   task automatic run_requests(input int target, input bit from_rows);
      int           counted;
      bit           pending;
      bit           accepted;
      bit           ignored;
      bus_req_t     cur;
      bit           cur_typed;
      rsp_item_type cur_want;
      rsp_item_type result;
      stim_row_t    row;
      counted = 0;
      pending = 1'b0;
      cur_typed = 1'b0;
      cur_want = '0;
      cur = '0;
      forever begin
         @(posedge clock);
         accepted = req_valid && !req_stall;
         if (accepted) begin
            ignored = (cur.kind == KIND_CMD) && (seq_phase != PH_IDLE);
            result = predict_bus_step(cur);
            expected_rsp_q.push_back(cur_typed ? cur_want : result);
            if (!ignored) counted++;
            pending = 1'b0;
         end
         if (!pending) begin
            if (from_rows && stim_rows.size() != 0) begin
               row = stim_rows.pop_front();
               cur = row.req;
               cur_typed = row.typed;
               cur_want = row.want;
               pending = 1'b1;
            end else if (!from_rows && !(counted >= target && seq_phase == PH_IDLE)) begin
               cur = next_bus_request();
               cur_typed = 1'b0;
               pending = 1'b1;
            end
            if (pending) begin
               req_kind <= cur.kind;
               req_op <= cur.op;
               req_dev_addr <= cur.dev_addr;
               req_reg_addr <= cur.reg_addr;
               req_write_data <= cur.write_data;
               req_read_len <= cur.read_len;
               req_sda_sample <= cur.sda_sample;
            end
         end
         if (!pending) begin
            req_valid <= 1'b0;
            break;
         end
         if (!req_valid || accepted)
            req_valid <= ($urandom_range(99) >= send_idle_pct);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed requests with both timeouts at zero.
      csr_write(REG_IDLE_TIMEOUT, 32'd0);
      csr_write(REG_ACK_TIMEOUT, 32'd0);
      add_row(make_req(KIND_TICK, OP_RESERVED, 8'hFF, 8'hFF, 8'hFF, 9'h1FF, 1'b0), 1, RSP_IDLE);
      add_row(make_req(KIND_TICK, OP_BYTE_WRITE, 8'h00, 8'h00, 8'h00, 9'd0, 1'b1), 1, RSP_IDLE);
      add_row(make_req(KIND_CMD, OP_BYTE_WRITE, 8'hFF, 8'h00, 8'hFF, 9'd0, 1'b0), 1,
              RSP_CHECKING);
      add_row(make_req(KIND_CMD, OP_BURST_READ, 8'h00, 8'hFF, 8'h00, 9'd256, 1'b1), 1,
              RSP_CHECKING);
      add_row(make_req(KIND_TICK, OP_BYTE_WRITE, 8'h00, 8'h00, 8'h00, 9'd0, 1'b0), 1,
              RSP_BUS_BUSY);
      add_row(make_req(KIND_CMD, OP_RESERVED, 8'h00, 8'hFF, 8'h00, 9'h1FF, 1'b0), 1,
              RSP_CHECKING);
      add_row(make_req(KIND_TICK, OP_BYTE_READ, 8'hA5, 8'h5A, 8'h3C, 9'd1, 1'b1), 0, '0);
      add_row(make_req(KIND_TICK, OP_BYTE_READ, 8'h5A, 8'hA5, 8'hC3, 9'd2, 1'b0), 0, '0);
      for (int i = 0; i < 18; i++)
         add_row(make_req(KIND_TICK, OP_BYTE_WRITE, 8'h00, 8'h00, 8'h00, 9'd0, i[0]), 0, '0);
      add_row(make_req(KIND_TICK, OP_BYTE_WRITE, 8'h00, 8'h00, 8'h00, 9'd0, 1'b1), 0, '0);
      add_row(make_req(KIND_TICK, OP_BYTE_WRITE, 8'h00, 8'h00, 8'h00, 9'd0, 1'b1), 0, '0);
      add_row(make_req(KIND_TICK, OP_BYTE_WRITE, 8'h00, 8'h00, 8'h00, 9'd0, 1'b0), 1,
              RSP_ADDR_NACK);
      run_requests(0, 1'b1);

      // Random transactions, one timeout setting and line activity per phase.
      for (int ph = 0; ph < 4; ph++) begin
         wait_for_results();
         csr_write(REG_IDLE_TIMEOUT, IDLE_SETTINGS[ph]);
         csr_write(REG_ACK_TIMEOUT, ACK_SETTINGS[ph]);
         send_idle_pct = SEND_IDLE_PCT[ph];
         stall_pct = STALL_PCT[ph];
         run_requests(PHASE_REQUESTS, 1'b0);
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("i2c_master_register_access test passed");
      end else begin
         $display("i2c_master_register_access test failed");
      end
      $finish;
   end

   // Ends a run that hangs.
   initial begin
      #10000000;
      $display("i2c_master_register_access test failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/imra_pkg.sv
rtl/core/imra_front.sv
rtl/core/imra_queue.sv
rtl/core/imra_back.sv
rtl/core/i2c_master_register_access.sv
test/tb_i2c_master_register_access.sv
